// ===== hw/rtl/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

  localparam int IN_W        = 8;
  localparam int IDX_W       = 9;
  localparam int RADIUS_W    = 16;
  localparam int CNT_CFG_W   = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int POS_W       = 17;
  localparam int TEX_W       = 17;
  localparam int TEX_FRAC    = 16;
  localparam int CORNER_W    = 3;
  localparam int TRIG_W      = 18;
  localparam int MUL1_W      = 35;
  localparam int PROD_W      = 53;
  localparam int ANG_W       = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT  = CORDIC_STEPS + 1;
  localparam int CORDIC_X_W  = 34;
  localparam int CORDIC_Z_W  = 33;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACKS = 2'd2;

  localparam logic [RADIUS_W-1:0]  RADIUS_RST = 16'd256;
  localparam logic [CNT_CFG_W-1:0] COUNT_RST  = 9'd16;

  localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;
  localparam logic [5:0] CORNER_DN = 6'b101001;
  localparam logic [5:0] CORNER_DM = 6'b110100;

  localparam logic signed [CORDIC_X_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [PROD_W-1:0] POS_MAX = 53'sd65535;
  localparam logic signed [PROD_W-1:0] POS_MIN = -53'sd65535;

  typedef struct packed {
    logic                valid;
    logic                bad;
    logic                last;
    logic [CORNER_W-1:0] corner;
    logic [IDX_W-1:0]    n;
    logic [IDX_W-1:0]    m;
  } beat_t;

  typedef struct packed {
    logic                valid;
    logic                bad;
    logic                last;
    logic [CORNER_W-1:0] corner;
    logic [TEX_W-1:0]    tex_u;
    logic [TEX_W-1:0]    tex_v;
  } side_t;

  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] r;
    case (k)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10680862;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41721;
      15: r = 32'd20860;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2607;
      19: r = 32'd1303;
      20: r = 32'd651;
      21: r = 32'd325;
      22: r = 32'd162;
      23: r = 32'd81;
      24: r = 32'd40;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd2;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    logic signed [POS_W-1:0]  r;
    t = (p + 53'sd2147483648) >>> 32;
    if (t > POS_MAX) r = 17'sd65535;
    else if (t < POS_MIN) r = -17'sd65535;
    else r = POS_W'(t);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/uv_sphere_tessellator.sv =====
`default_nettype none
// UV sphere cell generator.
// Input: pulse start with in_stack_index/in_slice_index while busy is low;
// the cell is taken at that edge. Each cell yields six vertex beats on the
// out_ ports, one per cycle, each marked by out_strobe for a single cycle,
// in corner order 0..5 with out_last on corner 5. A cell whose index is at
// or above its count yields one beat with out_bad_index and out_last set
// and every other field zero.
// Busy stays high while a good cell's corners are issued by the one-vertex
// per cycle sequencer and falls on its last beat (at once for a bad cell),
// so the next cell can be taken while the previous one's last beat issues.
// Pipeline: the angle and texture dividers (one bit per stage), the angle
// registers, thirty CORDIC stages plus the rounding stage, and three stages
// of scaling and saturation.
// Configuration: cfg_we with cfg_index 0 (radius), 1 (slices), 2 (stacks);
// write only while idle. Reset loads radius 1.0 and 16 slices and stacks
// and empties the pipeline. Results cannot be held off by the receiver.
module uv_sphere_tessellator #(
  parameter int MAX_DIVISIONS = 256,
  parameter int ANGLE_BITS    = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire [uvs_pkg::IN_W-1:0]             in_stack_index,
  input  wire [uvs_pkg::IN_W-1:0]             in_slice_index,
  input  wire                                 cfg_we,
  input  wire [uvs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [uvs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic                                out_strobe,
  output logic signed [uvs_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]    out_pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]    out_pos_z,
  output logic [uvs_pkg::TEX_W-1:0]           out_tex_u,
  output logic [uvs_pkg::TEX_W-1:0]           out_tex_v,
  output logic [uvs_pkg::CORNER_W-1:0]        out_corner,
  output logic                                out_bad_index,
  output logic                                out_last
);
  import uvs_pkg::*;

  localparam int CW   = $clog2(MAX_DIVISIONS + 1);
  localparam int CMPW = (CW > CNT_CFG_W) ? CW : CNT_CFG_W;
  localparam int QW   = ((ANGLE_BITS > TEX_FRAC) ? ANGLE_BITS : TEX_FRAC) + 1;
  localparam int DW   = QW + IDX_W;
  localparam int LB   = 1 + CORDIC_LAT + 2;

  logic [RADIUS_W-1:0]  radius_r;
  logic [CNT_CFG_W-1:0] slice_r, stack_r;
  logic [CW-1:0]        sl, st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      slice_r  <= COUNT_RST;
      stack_r  <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: radius_r <= cfg_wdata;
        REG_SLICES: slice_r  <= cfg_wdata[CNT_CFG_W-1:0];
        REG_STACKS: stack_r  <= cfg_wdata[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign sl = (CMPW'(slice_r) > CMPW'(MAX_DIVISIONS)) ? CW'(MAX_DIVISIONS) : CW'(slice_r);
  assign st = (CMPW'(stack_r) > CMPW'(MAX_DIVISIONS)) ? CW'(MAX_DIVISIONS) : CW'(stack_r);

  beat_t beat;

  uvs_seq #(.CW(CW)) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_stack_index (in_stack_index),
    .in_slice_index (in_slice_index),
    .slices         (sl),
    .stacks         (st),
    .busy           (busy),
    .beat           (beat)
  );

  logic [DW-1:0] d_lon, d_lat, d_u, d_v;
  logic [QW-1:0] q_lon, q_lat, q_u, q_v;

  assign d_lon = (DW'(beat.m) << ANGLE_BITS) + DW'(sl >> 1);
  assign d_lat = (DW'(beat.n) << (ANGLE_BITS - 1)) + DW'(st >> 1);
  assign d_u   = (DW'(beat.m) << TEX_FRAC) + DW'(sl >> 1);
  assign d_v   = (DW'(beat.n) << TEX_FRAC) + DW'(st >> 1);

  uvs_div #(.CW(CW), .QW(QW), .DW(DW)) u_div_lon (
    .clk(clk), .dividend(d_lon), .divisor(sl), .quotient(q_lon));
  uvs_div #(.CW(CW), .QW(QW), .DW(DW)) u_div_lat (
    .clk(clk), .dividend(d_lat), .divisor(st), .quotient(q_lat));
  uvs_div #(.CW(CW), .QW(QW), .DW(DW)) u_div_u (
    .clk(clk), .dividend(d_u), .divisor(sl), .quotient(q_u));
  uvs_div #(.CW(CW), .QW(QW), .DW(DW)) u_div_v (
    .clk(clk), .dividend(d_v), .divisor(st), .quotient(q_v));

  side_t side0, side_mid;
  side_t a_r [QW];
  side_t b_r [LB];

  always_comb begin
    side0.valid  = beat.valid;
    side0.bad    = beat.bad;
    side0.last   = beat.last;
    side0.corner = beat.bad ? '0 : beat.corner;
    side0.tex_u  = '0;
    side0.tex_v  = '0;
    side_mid       = a_r[QW-1];
    side_mid.tex_u = a_r[QW-1].bad ? '0 : TEX_W'(q_u);
    side_mid.tex_v = a_r[QW-1].bad ? '0 : TEX_W'(q_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) a_r[k] <= '0;
      for (int k = 0; k < LB; k++) b_r[k] <= '0;
    end else begin
      a_r[0] <= side0;
      for (int k = 1; k < QW; k++) a_r[k] <= a_r[k-1];
      b_r[0] <= side_mid;
      for (int k = 1; k < LB; k++) b_r[k] <= b_r[k-1];
    end
  end

  logic [ANG_W-1:0]      lon_ang_r, lat_ang_r;
  logic [ANGLE_BITS-1:0] lat_turn;

  assign lat_turn = q_lat[ANGLE_BITS-1:0] + ANGLE_BITS'(3 << (ANGLE_BITS - 2));

  always_ff @(posedge clk) begin
    lon_ang_r <= ANG_W'(q_lon[ANGLE_BITS-1:0]) << (ANG_W - ANGLE_BITS);
    lat_ang_r <= ANG_W'(lat_turn) << (ANG_W - ANGLE_BITS);
  end

  logic signed [TRIG_W-1:0] clat, slat, clon, slon;

  uvs_cordic u_cordic_lat (.clk(clk), .angle(lat_ang_r), .cos_o(clat), .sin_o(slat));
  uvs_cordic u_cordic_lon (.clk(clk), .angle(lon_ang_r), .cos_o(clon), .sin_o(slon));

  logic signed [MUL1_W-1:0] rc_r, ry_r;
  logic signed [TRIG_W-1:0] clon_r, slon_r;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    rc_r   <= $signed({1'b0, radius_r}) * clat;
    ry_r   <= $signed({1'b0, radius_r}) * slat;
    clon_r <= clon;
    slon_r <= slon;
    px_r   <= rc_r * slon_r;
    pz_r   <= rc_r * clon_r;
    py_r   <= PROD_W'(ry_r) <<< TEX_FRAC;
  end

  logic                     strobe_r;
  logic signed [POS_W-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic [TEX_W-1:0]         tex_u_r, tex_v_r;
  logic [CORNER_W-1:0]      corner_r;
  logic                     bad_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= b_r[LB-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r  <= b_r[LB-1].bad ? '0 : round_sat(px_r);
    pos_y_r  <= b_r[LB-1].bad ? '0 : round_sat(py_r);
    pos_z_r  <= b_r[LB-1].bad ? '0 : round_sat(pz_r);
    tex_u_r  <= b_r[LB-1].tex_u;
    tex_v_r  <= b_r[LB-1].tex_v;
    corner_r <= b_r[LB-1].corner;
    bad_r    <= b_r[LB-1].bad;
    last_r   <= b_r[LB-1].last;
  end

  assign out_strobe    = strobe_r;
  assign out_pos_x     = pos_x_r;
  assign out_pos_y     = pos_y_r;
  assign out_pos_z     = pos_z_r;
  assign out_tex_u     = tex_u_r;
  assign out_tex_v     = tex_v_r;
  assign out_corner    = corner_r;
  assign out_bad_index = bad_r;
  assign out_last      = last_r;

  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_bad_index |-> out_last)
    else $error("bad beat not marked last");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_bad_index |-> out_pos_x == 0 && out_pos_y == 0 &&
      out_pos_z == 0 && out_tex_u == 0 && out_tex_v == 0 && out_corner == 0)
    else $error("bad beat carries data");

  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe && !out_bad_index &&
      out_corner == $past(out_corner) + 3'd1)
    else $error("vertex run broken");

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last && !out_bad_index |-> out_corner == LAST_CORNER)
    else $error("last beat on wrong corner");

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_seq.sv =====
`default_nettype none
module uvs_seq #(
  parameter int CW = 9
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [uvs_pkg::IN_W-1:0]      in_stack_index,
  input  wire [uvs_pkg::IN_W-1:0]      in_slice_index,
  input  wire [CW-1:0]                 slices,
  input  wire [CW-1:0]                 stacks,
  output logic                         busy,
  output uvs_pkg::beat_t               beat
);
  import uvs_pkg::*;

  localparam int CMPW = (CW > IN_W) ? CW : IN_W;

  logic                active_r, active_nxt;
  logic [CORNER_W-1:0] k_r, k_nxt;
  logic [IN_W-1:0]     i_r, j_r;
  logic                bad_r;
  logic                last_now, accept, bad_in;

  assign last_now = bad_r || (k_r == LAST_CORNER);
  assign busy     = active_r && !last_now;
  assign accept   = start && !busy;
  assign bad_in   = (CMPW'(in_stack_index) >= CMPW'(stacks)) ||
                    (CMPW'(in_slice_index) >= CMPW'(slices));

  always_comb begin
    active_nxt = active_r;
    k_nxt      = k_r;
    if (accept) begin
      active_nxt = 1'b1;
      k_nxt      = '0;
    end else if (active_r) begin
      if (last_now) begin
        active_nxt = 1'b0;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      k_r      <= '0;
    end else begin
      active_r <= active_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_r   <= in_stack_index;
      j_r   <= in_slice_index;
      bad_r <= bad_in;
    end
  end

  always_comb begin
    beat.valid  = active_r;
    beat.bad    = bad_r;
    beat.last   = last_now;
    beat.corner = k_r;
    beat.n      = IDX_W'(i_r) + IDX_W'(CORNER_DN[k_r]);
    beat.m      = IDX_W'(j_r) + IDX_W'(CORNER_DM[k_r]);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_div.sv =====
`default_nettype none
module uvs_div #(
  parameter int CW = 9,
  parameter int QW = 17,
  parameter int DW = 26
) (
  input  wire          clk,
  input  wire [DW-1:0] dividend,
  input  wire [CW-1:0] divisor,
  output logic [QW-1:0] quotient
);

  logic [CW-1:0] rem_r   [QW];
  logic [QW-1:0] low_r   [QW];
  logic [QW-1:0] q_r     [QW];
  logic [CW-1:0] rem_nxt [QW];
  logic [QW-1:0] low_nxt [QW];
  logic [QW-1:0] q_nxt   [QW];

  function automatic logic [CW:0] trial(input logic [CW-1:0] rem, input logic b);
    return {rem, b};
  endfunction

  always_comb begin
    logic [CW:0]   t;
    logic          ge;
    logic [CW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] q;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem = CW'(dividend[DW-1:QW]);
        low = dividend[QW-1:0];
        q   = '0;
      end else begin
        rem = rem_r[k-1];
        low = low_r[k-1];
        q   = q_r[k-1];
      end
      t  = trial(rem, low[QW-1]);
      ge = t >= {1'b0, divisor};
      rem_nxt[k] = ge ? CW'(t - {1'b0, divisor}) : CW'(t);
      low_nxt[k] = low << 1;
      q_nxt[k]   = {q[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      rem_r[k] <= rem_nxt[k];
      low_r[k] <= low_nxt[k];
      q_r[k]   <= q_nxt[k];
    end
  end

  assign quotient = q_r[QW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_cordic.sv =====
`default_nettype none
module uvs_cordic (
  input  wire                                   clk,
  input  wire [uvs_pkg::ANG_W-1:0]              angle,
  output logic signed [uvs_pkg::TRIG_W-1:0]     cos_o,
  output logic signed [uvs_pkg::TRIG_W-1:0]     sin_o
);
  import uvs_pkg::*;

  localparam int NS = CORDIC_STEPS;
  localparam int XW = CORDIC_X_W;
  localparam int ZW = CORDIC_Z_W;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
  } cstate_t;

  function automatic cstate_t step(input cstate_t s, input int k);
    cstate_t              r;
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    dx = s.y >>> k;
    dy = s.x >>> k;
    at = $signed({1'b0, atan_turn(k)});
    r  = s;
    if (!s.z[ZW-1]) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - at;
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + at;
    end
    return r;
  endfunction

  cstate_t st_r   [NS];
  cstate_t st_nxt [NS];
  cstate_t s0;
  logic signed [XW-1:0]     cr, sr;
  logic signed [TRIG_W-1:0] c, s;
  logic signed [TRIG_W-1:0] cos_r, sin_r;

  always_comb begin
    s0.x      = CORDIC_GAIN;
    s0.y      = '0;
    s0.z      = ZW'(angle[29:0]);
    s0.quad   = angle[31:30];
    st_nxt[0] = step(s0, 0);
    for (int k = 1; k < NS; k++) begin
      st_nxt[k] = step(st_r[k-1], k);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  assign cr = (st_r[NS-1].x + XW'(8192)) >>> 14;
  assign sr = (st_r[NS-1].y + XW'(8192)) >>> 14;
  assign c  = TRIG_W'(cr);
  assign s  = TRIG_W'(sr);

  always_ff @(posedge clk) begin
    case (st_r[NS-1].quad)
      2'd0: begin cos_r <= c;  sin_r <= s;  end
      2'd1: begin cos_r <= -s; sin_r <= c;  end
      2'd2: begin cos_r <= -c; sin_r <= -s; end
      default: begin cos_r <= s; sin_r <= -c; end
    endcase
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire
